// ===== sv/irpd_pkg.sv =====
// Shared types, register codes and window helper for the IR pulse width decoder.
package irpd_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned WidthW  = 16;
  localparam int unsigned IdleW   = 16;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned HeldW   = 6;
  localparam int unsigned LenW    = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  // Wide enough for an effective packet length up to 64.
  localparam int unsigned EffLenW = 7;

  // Register reset values.
  localparam logic [WidthW-1:0] ShortResetUs = 16'd400;
  localparam logic [WidthW-1:0] LongResetUs  = 16'd800;
  localparam logic [WidthW-1:0] StartResetUs = 16'd0;
  localparam logic [WidthW-1:0] TolResetUs   = 16'd100;
  localparam logic [IdleW-1:0]  GapResetMs   = 16'd50;
  localparam logic [LenW-1:0]   LenReset     = 6'd32;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SHORT_PULSE = 3'd0,
    CFG_LONG_PULSE  = 3'd1,
    CFG_START_PULSE = 3'd2,
    CFG_TOLERANCE   = 3'd3,
    CFG_GAP         = 3'd4,
    CFG_PKT_LENGTH  = 3'd5
  } cfg_idx_e;

  // Classification of one pulse.
  typedef enum logic [1:0] {
    CLS_START = 2'd0,
    CLS_ZERO  = 2'd1,
    CLS_ONE   = 2'd2,
    CLS_NONE  = 2'd3
  } pulse_class_e;

  // Strict window test: nominal - tol (floored at zero) < w < nominal + tol.
  function automatic logic in_window(input logic [WidthW-1:0] w,
                                     input logic [WidthW-1:0] nominal,
                                     input logic [WidthW-1:0] tol);
    logic [WidthW-1:0] lo;
    logic [WidthW:0]   hi;
    lo = (nominal > tol) ? (nominal - tol) : '0;
    hi = {1'b0, nominal} + {1'b0, tol};
    return (w > lo) && ({1'b0, w} < hi);
  endfunction

endpackage

// ===== sv/irpd_if.sv =====
// Valid/ready channel interfaces for pulse beats and decode result beats.
interface irpd_in_if;
  import irpd_pkg::*;
  logic              valid;
  logic              ready;
  logic [WidthW-1:0] pulse_width_us;
  logic [IdleW-1:0]  idle_ms;

  modport source (output valid, output pulse_width_us, output idle_ms, input ready);
  modport sink   (input valid, input pulse_width_us, input idle_ms, output ready);
endinterface

interface irpd_out_if;
  import irpd_pkg::*;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] packet_value;
  logic [HeldW-1:0]  bits_held;
  logic [1:0]        pulse_class;
  logic              packet_done;

  modport source (output valid, output packet_value, output bits_held,
                  output pulse_class, output packet_done, input ready);
  modport sink   (input valid, input packet_value, input bits_held,
                  input pulse_class, input packet_done, output ready);
endinterface

// ===== sv/pulse_width_ir_packet_decoder_top.sv =====
// Top level of the pulse width IR packet decoder.
// Each input beat carries one measured pulse width and the idle time since the previous
// pulse; each beat yields exactly one result beat with the packet bits so far, the bit
// count, the pulse class and a done flag. The pulse is classified against the start,
// short and long windows (strict bounds, nominal plus or minus the tolerance), bits are
// shifted in newest at bit 0, and the packet clears after a start pulse, after an
// unmatched pulse that follows a long idle gap, and right after a completed packet.
// The block takes one beat per cycle while the output is not stalled: a beat is
// registered, then classified and merged into the packet state combinationally, and its
// result is captured in the result register. While a result waits at the output the
// input register takes one more beat and then holds ready low until the result is taken;
// input ready follows output ready combinationally. Configuration registers must be
// written only while no beat is in flight; the block itself does not enforce it.
module pulse_width_ir_packet_decoder_top #(
  parameter int unsigned MAX_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [irpd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [irpd_pkg::CfgDataW-1:0] cfg_data_i,
  irpd_in_if.sink                      in_i,
  irpd_out_if.source                   out_o
);
  import irpd_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_BITS + 1);

  // Configuration registers.
  logic [WidthW-1:0] short_us_q, long_us_q, start_us_q, tol_us_q;
  logic [IdleW-1:0]  gap_ms_q;
  logic [LenW-1:0]   pkt_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_us_q <= ShortResetUs;
      long_us_q  <= LongResetUs;
      start_us_q <= StartResetUs;
      tol_us_q   <= TolResetUs;
      gap_ms_q   <= GapResetMs;
      pkt_len_q  <= LenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SHORT_PULSE: short_us_q <= cfg_data_i;
        CFG_LONG_PULSE:  long_us_q  <= cfg_data_i;
        CFG_START_PULSE: start_us_q <= cfg_data_i;
        CFG_TOLERANCE:   tol_us_q   <= cfg_data_i;
        CFG_GAP:         gap_ms_q   <= cfg_data_i;
        CFG_PKT_LENGTH:  pkt_len_q  <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Input register stage.
  logic              s1_valid_q;
  logic [WidthW-1:0] s1_width_q;
  logic [IdleW-1:0]  s1_idle_q;
  logic              s1_advance;
  logic              in_fire;

  assign s1_advance = s1_valid_q && (!out_o.valid || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_advance;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_width_q <= in_i.pulse_width_us;
      s1_idle_q  <= in_i.idle_ms;
    end
  end

  // Packet state.
  logic [MAX_BITS-1:0] store_q, store_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  // Decode logic for the registered beat.
  logic [EffLenW-1:0]    eff_len;
  logic [MAX_BITS-1:0]   len_mask;
  logic [CntW-1:0]       cnt_inc;
  logic [CntW+EffLenW-1:0] cnt_ext;
  logic [MAX_BITS+ValueW-1:0] val_ext;
  pulse_class_e          cls;
  logic                  is_bit;
  logic                  done;
  logic [MAX_BITS-1:0]   res_value;
  logic [CntW-1:0]       res_cnt;
  logic [ValueW-1:0]     value_d;
  logic [HeldW-1:0]      held_d;

  // Effective length: zero acts as one, clipped to the store width.
  always_comb begin
    eff_len = (pkt_len_q == '0) ? EffLenW'(1) : EffLenW'(pkt_len_q);
    if (eff_len > EffLenW'(MAX_BITS)) begin
      eff_len = EffLenW'(MAX_BITS);
    end
    for (int i = 0; i < MAX_BITS; i++) begin
      len_mask[i] = (EffLenW'(i) < eff_len);
    end
  end

  // Window classification in priority order: start (only when its nominal is nonzero), short, long.
  always_comb begin
    if (start_us_q != '0 && in_window(s1_width_q, start_us_q, tol_us_q)) begin
      cls = CLS_START;
    end else if (in_window(s1_width_q, short_us_q, tol_us_q)) begin
      cls = CLS_ZERO;
    end else if (in_window(s1_width_q, long_us_q, tol_us_q)) begin
      cls = CLS_ONE;
    end else begin
      cls = CLS_NONE;
    end
  end

  // Shift, count and completion.
  always_comb begin
    is_bit    = (cls == CLS_ZERO) || (cls == CLS_ONE);
    cnt_inc   = cnt_q + CntW'(1);
    res_value = store_q;
    res_cnt   = cnt_q;
    case (cls) inside
      CLS_START: begin
        res_value = '0;
        res_cnt   = '0;
      end
      CLS_ZERO, CLS_ONE: begin
        res_value = ((store_q << 1) | MAX_BITS'(cls == CLS_ONE)) & len_mask;
        res_cnt   = cnt_inc;
      end
      default: begin
        if (s1_idle_q > gap_ms_q) begin
          res_value = '0;
          res_cnt   = '0;
        end
      end
    endcase
    cnt_ext = {EffLenW'(0), res_cnt};
    done    = is_bit && (cnt_ext[EffLenW-1:0] >= eff_len);
    val_ext = {ValueW'(0), res_value};
    value_d = val_ext[ValueW-1:0];
    held_d  = done ? eff_len[HeldW-1:0] : cnt_ext[HeldW-1:0];
    store_d = done ? '0 : res_value;
    cnt_d   = done ? '0 : res_cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      cnt_q   <= '0;
    end else if (s1_advance) begin
      store_q <= store_d;
      cnt_q   <= cnt_d;
    end
  end

  // Result register.
  logic              out_valid_q;
  logic [ValueW-1:0] out_value_q;
  logic [HeldW-1:0]  out_held_q;
  pulse_class_e      out_class_q;
  logic              out_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_value_q <= value_d;
      out_held_q  <= held_d;
      out_class_q <= cls;
      out_done_q  <= done;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.packet_value = out_value_q;
  assign out_o.bits_held    = out_held_q;
  assign out_o.pulse_class  = out_class_q;
  assign out_o.packet_done  = out_done_q;

  // A completed packet only comes from a data bit.
  a_done_on_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_done_q |-> (out_class_q == CLS_ZERO || out_class_q == CLS_ONE))
    else $error("packet_done on a pulse that is not a data bit");

  // A start pulse reports an empty packet.
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_class_q == CLS_START |-> out_held_q == '0 && !out_done_q)
    else $error("start pulse did not clear the packet");

  // The bit count never runs past the store width.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {EffLenW'(0), cnt_q} <= (CntW + EffLenW)'(MAX_BITS))
    else $error("bit count beyond store width");

  // A completed packet leaves the state empty for the next one.
  a_done_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance && done |=> cnt_q == '0 && store_q == '0)
    else $error("state not cleared after a completed packet");

endmodule
